// ----- src/hslm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hslm_pkg;

    localparam int POSITION_BITS = 16;
    localparam int NUM_METHODS = 9;
    localparam int OUT_DATA_BITS = 56;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT = 8'h2E;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        RQ_METHOD,
        RQ_SLASH,
        RQ_TARGET,
        RQ_H,
        RQ_T1,
        RQ_T2,
        RQ_P,
        RQ_SL,
        RQ_MAJOR,
        RQ_DOT,
        RQ_MINOR,
        RQ_TERM,
        RQ_DONE,
        RQ_FAIL
    } rq_phase_t;

    typedef enum logic [1:0] {
        RS_PREFIX,
        RS_REASON,
        RS_FAIL
    } rs_phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  method;
        logic [3:0]  version_major;
        logic [3:0]  version_minor;
        logic [9:0]  status_code;
        logic [15:0] target_length;
        logic [15:0] reason_length;
    } result_t;

    localparam logic [7:0] METHOD_TEXT [NUM_METHODS][8] = '{
        '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h55, 8'h54, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45, 8'h20, 8'h00},
        '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h50, 8'h54, 8'h49, 8'h4F, 8'h4E, 8'h53, 8'h20},
        '{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h20, 8'h00, 8'h00},
        '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54, 8'h20},
        '{8'h54, 8'h52, 8'h41, 8'h43, 8'h45, 8'h20, 8'h00, 8'h00}
    };

    localparam logic [3:0] METHOD_BYTES [NUM_METHODS] = '{
        4'd4, 4'd5, 4'd4, 4'd7, 4'd5, 4'd8, 4'd6, 4'd8, 4'd6
    };

    localparam logic [7:0] HTTP_TEXT [5] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F};

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// ----- src/hslm_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hslm_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // payload_byte
    input  wire logic          s_axis_tlast,
    input  wire logic          advance,
    output logic               valid,
    output hslm_pkg::item_t    item
);

    logic            valid_reg;
    logic            valid_next;
    hslm_pkg::item_t item_reg;

    assign s_axis_tready = !valid_reg || advance;
    assign valid_next = s_axis_tready ? s_axis_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.payload_byte <= s_axis_tdata;
            item_reg.last_byte <= s_axis_tlast;
        end
    end

    assign valid = valid_reg;
    assign item = item_reg;

endmodule

`default_nettype wire

// ----- src/hslm_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hslm_parse (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire hslm_pkg::item_t item,
    output hslm_pkg::result_t  result
);

    localparam int PB = hslm_pkg::POSITION_BITS;
    localparam int NM = hslm_pkg::NUM_METHODS;
    localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

    logic [PB-1:0]         pos_reg, pos_next;
    logic [NM-1:0]         cand_reg, cand_next;
    hslm_pkg::rq_phase_t   rq_reg, rq_next;
    hslm_pkg::rs_phase_t   rs_reg, rs_next;
    logic [3:0]            method_reg, method_next;
    logic [PB-1:0]         target_reg, target_next;
    logic [7:0]            ver_reg, ver_next;
    logic [9:0]            status_reg, status_next;
    logic                  cr_seen_reg, cr_seen_next;
    logic [PB-1:0]         cr_off_reg, cr_off_next;
    logic                  lf_seen_reg, lf_seen_next;
    logic [PB-1:0]         lf_off_reg, lf_off_next;

    logic [7:0]            b;
    logic                  pos_small;
    logic [2:0]            idx;
    logic [NM-1:0]         hit;
    logic [NM-1:0]         done;
    logic [3:0]            done_idx;
    logic [12:0]           status_x10;
    logic [PB-1:0]         reason_off;
    logic                  rs_ok;
    logic                  req_match;
    logic                  rsp_match;

    assign b = item.payload_byte;
    assign pos_small = (pos_reg[PB-1:3] == '0);
    assign idx = pos_reg[2:0];
    assign status_x10 = {status_reg, 3'b000} + {2'b00, status_reg, 1'b0};
    assign reason_off = pos_reg - PB'(13);

    always_comb
    begin
        hit = '0;
        done = '0;
        done_idx = 4'd0;
        for (int m = 0; m < NM; m++)
        begin
            hit[m] = cand_reg[m] && pos_small && ({1'b0, idx} < hslm_pkg::METHOD_BYTES[m])
                && (hslm_pkg::METHOD_TEXT[m][idx] == b);
            done[m] = hit[m] && (({1'b0, idx} + 4'd1) == hslm_pkg::METHOD_BYTES[m]);
            if (done[m])
            begin
                done_idx = 4'(m);
            end
        end
    end

    always_comb
    begin
        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + PB'(1);
        cand_next = cand_reg;
        rq_next = rq_reg;
        rs_next = rs_reg;
        method_next = method_reg;
        target_next = target_reg;
        ver_next = ver_reg;
        status_next = status_reg;
        cr_seen_next = cr_seen_reg;
        cr_off_next = cr_off_reg;
        lf_seen_next = lf_seen_reg;
        lf_off_next = lf_off_reg;
        rs_ok = 1'b0;

        case (rq_reg)
            hslm_pkg::RQ_METHOD:
            begin
                cand_next = hit;
                if (|done)
                begin
                    method_next = done_idx;
                    rq_next = hslm_pkg::RQ_SLASH;
                end
                if (hit == '0)
                begin
                    rq_next = hslm_pkg::RQ_FAIL;
                end
            end
            hslm_pkg::RQ_SLASH:
            begin
                if (b == hslm_pkg::CH_SLASH)
                begin
                    target_next = PB'(1);
                    rq_next = hslm_pkg::RQ_TARGET;
                end
                else
                begin
                    rq_next = hslm_pkg::RQ_FAIL;
                end
            end
            hslm_pkg::RQ_TARGET:
            begin
                if (b == hslm_pkg::CH_SPACE)
                begin
                    rq_next = hslm_pkg::RQ_H;
                end
                else if (target_reg != POS_MAX)
                begin
                    target_next = target_reg + PB'(1);
                end
            end
            hslm_pkg::RQ_H:
            begin
                rq_next = (b == hslm_pkg::HTTP_TEXT[0]) ? hslm_pkg::RQ_T1 : hslm_pkg::RQ_FAIL;
            end
            hslm_pkg::RQ_T1:
            begin
                rq_next = (b == hslm_pkg::HTTP_TEXT[1]) ? hslm_pkg::RQ_T2 : hslm_pkg::RQ_FAIL;
            end
            hslm_pkg::RQ_T2:
            begin
                rq_next = (b == hslm_pkg::HTTP_TEXT[2]) ? hslm_pkg::RQ_P : hslm_pkg::RQ_FAIL;
            end
            hslm_pkg::RQ_P:
            begin
                rq_next = (b == hslm_pkg::HTTP_TEXT[3]) ? hslm_pkg::RQ_SL : hslm_pkg::RQ_FAIL;
            end
            hslm_pkg::RQ_SL:
            begin
                rq_next = (b == hslm_pkg::HTTP_TEXT[4]) ? hslm_pkg::RQ_MAJOR
                                                        : hslm_pkg::RQ_FAIL;
            end
            hslm_pkg::RQ_MAJOR:
            begin
                if (hslm_pkg::is_digit(b))
                begin
                    ver_next = {b[3:0], ver_reg[3:0]};
                    rq_next = hslm_pkg::RQ_DOT;
                end
                else
                begin
                    rq_next = hslm_pkg::RQ_FAIL;
                end
            end
            hslm_pkg::RQ_DOT:
            begin
                rq_next = (b == hslm_pkg::CH_DOT) ? hslm_pkg::RQ_MINOR : hslm_pkg::RQ_FAIL;
            end
            hslm_pkg::RQ_MINOR:
            begin
                if (hslm_pkg::is_digit(b))
                begin
                    ver_next = {ver_reg[7:4], b[3:0]};
                    rq_next = hslm_pkg::RQ_TERM;
                end
                else
                begin
                    rq_next = hslm_pkg::RQ_FAIL;
                end
            end
            hslm_pkg::RQ_TERM:
            begin
                rq_next = (b == hslm_pkg::CH_CR || b == hslm_pkg::CH_LF) ? hslm_pkg::RQ_DONE
                                                                         : hslm_pkg::RQ_FAIL;
            end
            hslm_pkg::RQ_DONE:
            begin
                rq_next = hslm_pkg::RQ_DONE;
            end
            default:
            begin
                rq_next = hslm_pkg::RQ_FAIL;
            end
        endcase

        case (rs_reg)
            hslm_pkg::RS_PREFIX:
            begin
                if (pos_reg[PB-1:4] == '0)
                begin
                    case (pos_reg[3:0])
                        4'd0, 4'd1, 4'd2, 4'd3, 4'd4:
                            rs_ok = (b == hslm_pkg::HTTP_TEXT[pos_reg[2:0]]);
                        4'd6:
                            rs_ok = (b == hslm_pkg::CH_DOT);
                        4'd8, 4'd12:
                            rs_ok = (b == hslm_pkg::CH_SPACE);
                        4'd5, 4'd7, 4'd9, 4'd10, 4'd11:
                            rs_ok = hslm_pkg::is_digit(b);
                        default:
                            rs_ok = 1'b0;
                    endcase
                end
                if (!rs_ok)
                begin
                    rs_next = hslm_pkg::RS_FAIL;
                end
                else if (pos_reg[3:0] == 4'd5)
                begin
                    ver_next = {b[3:0], ver_next[3:0]};
                end
                else if (pos_reg[3:0] == 4'd7)
                begin
                    ver_next = {ver_next[7:4], b[3:0]};
                end
                else if (pos_reg[3:0] >= 4'd9 && pos_reg[3:0] <= 4'd11)
                begin
                    status_next = status_x10[9:0] + {6'b000000, b[3:0]};
                end
                else if (pos_reg[3:0] == 4'd12)
                begin
                    rs_next = hslm_pkg::RS_REASON;
                end
            end
            hslm_pkg::RS_REASON:
            begin
                if (b == hslm_pkg::CH_CR && !cr_seen_reg)
                begin
                    cr_seen_next = 1'b1;
                    cr_off_next = reason_off;
                end
                if (b == hslm_pkg::CH_LF && !lf_seen_reg)
                begin
                    lf_seen_next = 1'b1;
                    lf_off_next = reason_off;
                end
            end
            default:
            begin
                rs_next = hslm_pkg::RS_FAIL;
            end
        endcase
    end

    assign req_match = (rq_next == hslm_pkg::RQ_DONE) && (pos_reg >= PB'(15));
    assign rsp_match = (rs_next == hslm_pkg::RS_REASON) && (cr_seen_next || lf_seen_next);

    always_comb
    begin
        result = '0;
        if (req_match)
        begin
            result.kind = hslm_pkg::KIND_REQUEST;
            result.method = method_next;
            result.version_major = ver_next[7:4];
            result.version_minor = ver_next[3:0];
            result.target_length = 16'(target_next);
        end
        else if (rsp_match)
        begin
            result.kind = hslm_pkg::KIND_STATUS;
            result.version_major = ver_next[7:4];
            result.version_minor = ver_next[3:0];
            result.status_code = status_next;
            result.reason_length = cr_seen_next ? 16'(cr_off_next) : 16'(lf_off_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cand_reg <= '1;
            rq_reg <= hslm_pkg::RQ_METHOD;
            rs_reg <= hslm_pkg::RS_PREFIX;
            method_reg <= '0;
            target_reg <= '0;
            ver_reg <= '0;
            status_reg <= '0;
            cr_seen_reg <= 1'b0;
            cr_off_reg <= '0;
            lf_seen_reg <= 1'b0;
            lf_off_reg <= '0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                pos_reg <= '0;
                cand_reg <= '1;
                rq_reg <= hslm_pkg::RQ_METHOD;
                rs_reg <= hslm_pkg::RS_PREFIX;
                method_reg <= '0;
                target_reg <= '0;
                ver_reg <= '0;
                status_reg <= '0;
                cr_seen_reg <= 1'b0;
                cr_off_reg <= '0;
                lf_seen_reg <= 1'b0;
                lf_off_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_next;
                cand_reg <= cand_next;
                rq_reg <= rq_next;
                rs_reg <= rs_next;
                method_reg <= method_next;
                target_reg <= target_next;
                ver_reg <= ver_next;
                status_reg <= status_next;
                cr_seen_reg <= cr_seen_next;
                cr_off_reg <= cr_off_next;
                lf_seen_reg <= lf_seen_next;
                lf_off_reg <= lf_off_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/hslm_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hslm_out_stage (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   load,
    input  wire hslm_pkg::result_t                      result,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [hslm_pkg::OUT_DATA_BITS-1:0]          m_axis_tdata,
    output logic [1:0]                                  m_axis_tuser
);

    logic              valid_reg;
    logic              valid_next;
    hslm_pkg::result_t result_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser = result_reg.kind;
    assign m_axis_tdata = {2'b00, result_reg.reason_length, result_reg.target_length,
                           result_reg.status_code, result_reg.version_minor,
                           result_reg.version_major, result_reg.method};

endmodule

`default_nettype wire

// ----- src/http_start_line_matcher_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s_axis    in         tdata[7:0] payload_byte, tlast last_byte
// m_axis    out        tuser kind, tdata method..reason_length (56 bits)
//
// One byte is taken every cycle unless a held result stalls input; the block
// is a two-stage pipeline of an input register and a result register, and a
// result is produced, only for a last byte, once it leaves the input register.
// Reset returns the parser to the start of a payload and empties both stages.
// A held result stalls input only when the next item in the input register is
// itself a last byte.

module http_start_line_matcher_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] payload_byte
    input  wire logic          s_axis_tlast,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // [3:0] method, [7:4] version_major, [11:8] version_minor,
    // [21:12] status_code, [37:22] target_length, [53:38] reason_length
    output logic [55:0]        m_axis_tdata,
    output logic [1:0]         m_axis_tuser    // [1:0] kind
);

    logic              in_valid;
    hslm_pkg::item_t   in_item;
    logic              advance;
    hslm_pkg::result_t result;

    assign advance = in_valid && (!in_item.last_byte || !m_axis_tvalid || m_axis_tready);

    hslm_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .valid         (in_valid),
        .item          (in_item)
    );

    hslm_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item),
        .result (result)
    );

    hslm_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && in_item.last_byte),
        .result        (result),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- src/hslm_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hslm_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          s_axis_tvalid,
    input wire logic          s_axis_tready,
    input wire logic          s_axis_tlast,
    input wire logic          m_axis_tvalid,
    input wire logic          m_axis_tready,
    input wire logic [55:0]   m_axis_tdata,
    input wire logic [1:0]    m_axis_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Result changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == hslm_pkg::KIND_NONE |-> m_axis_tdata == '0)
        else $error("No-match result carries nonzero fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == hslm_pkg::KIND_REQUEST |->
            m_axis_tdata[21:12] == '0 && m_axis_tdata[53:38] == '0
            && m_axis_tdata[37:22] != '0)
        else $error("Request result has status fields or an empty target.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == hslm_pkg::KIND_STATUS |->
            m_axis_tdata[3:0] == '0 && m_axis_tdata[37:22] == '0)
        else $error("Status result has request fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2)
            || !$past(s_axis_tready))
        else $error("Result appeared without a last item ahead of it.");

endmodule

bind http_start_line_matcher_top hslm_checker u_hslm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
